// ----- rtl/sfir_pkg.sv -----
// Shared constants and codes for the symmetric complex FIR filter.
// Used by sfir_cell, sfir_out and symmetric_fir_24tap_complex; depends on nothing.
`timescale 1ns / 1ps

package sfir_pkg;

    localparam int HALF_TAPS_DEF    = 12;
    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int COEF_W       = 16;
    localparam int COEF_REGS    = 3;
    localparam int COEF_PER_REG = 4;
    localparam int BANK_W       = COEF_W * COEF_PER_REG;

    localparam int SHIFT_W = 5;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd9;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_LOW  = 2'd0,
        CFG_COEF_MID  = 2'd1,
        CFG_COEF_HIGH = 2'd2,
        CFG_OUT_SHIFT = 2'd3
    } cfg_reg_t;

endpackage

// ----- rtl/sfir_cell.sv -----
// One tap-pair cell: two delay-line taps, pre-adder, multiplier, skew line and accumulator.
// Depends on sfir_pkg.
`timescale 1ns / 1ps

module sfir_cell #(
    parameter int SAMPLE_WIDTH = sfir_pkg::SAMPLE_WIDTH_DEF,
    parameter int ACC_W        = 40,
    parameter int DELAY        = 0
) (
    input  logic                                clk,
    input  logic                                shift_en,
    input  logic                                adv,
    input  logic signed [SAMPLE_WIDTH-1:0]      front_in_re,
    input  logic signed [SAMPLE_WIDTH-1:0]      front_in_im,
    input  logic signed [SAMPLE_WIDTH-1:0]      back_in_re,
    input  logic signed [SAMPLE_WIDTH-1:0]      back_in_im,
    output logic signed [SAMPLE_WIDTH-1:0]      front_out_re,
    output logic signed [SAMPLE_WIDTH-1:0]      front_out_im,
    output logic signed [SAMPLE_WIDTH-1:0]      back_out_re,
    output logic signed [SAMPLE_WIDTH-1:0]      back_out_im,
    input  logic signed [sfir_pkg::COEF_W-1:0]  coef,
    input  logic signed [ACC_W-1:0]             psum_in_re,
    input  logic signed [ACC_W-1:0]             psum_in_im,
    output logic signed [ACC_W-1:0]             psum_out_re,
    output logic signed [ACC_W-1:0]             psum_out_im
);

    localparam int PRE_W  = SAMPLE_WIDTH + 1;
    localparam int PROD_W = PRE_W + sfir_pkg::COEF_W;

    logic signed [SAMPLE_WIDTH-1:0] front_re_reg, front_im_reg;
    logic signed [SAMPLE_WIDTH-1:0] back_re_reg, back_im_reg;
    logic signed [PRE_W-1:0]        pre_re_next, pre_im_next;
    logic signed [PRE_W-1:0]        pre_re_reg, pre_im_reg;
    logic signed [PROD_W-1:0]       prod_re_next, prod_im_next;
    logic signed [PROD_W-1:0]       prod_re_reg, prod_im_reg;
    logic signed [PROD_W-1:0]       dly_re, dly_im;
    logic signed [ACC_W-1:0]        psum_re_reg, psum_im_reg;

    // The word entering this cell pairs with the word held in the back tap.
    assign pre_re_next  = PRE_W'(front_in_re) + PRE_W'(back_re_reg);
    assign pre_im_next  = PRE_W'(front_in_im) + PRE_W'(back_im_reg);
    assign prod_re_next = PROD_W'(pre_re_reg) * PROD_W'(coef);
    assign prod_im_next = PROD_W'(pre_im_reg) * PROD_W'(coef);

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            front_re_reg <= front_in_re;
            front_im_reg <= front_in_im;
            back_re_reg  <= back_in_re;
            back_im_reg  <= back_in_im;
        end
        if (adv)
        begin
            pre_re_reg  <= pre_re_next;
            pre_im_reg  <= pre_im_next;
            prod_re_reg <= prod_re_next;
            prod_im_reg <= prod_im_next;
            psum_re_reg <= psum_in_re + ACC_W'(dly_re);
            psum_im_reg <= psum_in_im + ACC_W'(dly_im);
        end
    end

    // Products wait here until the partial sum of the same word reaches this cell.
    generate
        if (DELAY == 0)
        begin : g_nodly
            assign dly_re = prod_re_reg;
            assign dly_im = prod_im_reg;
        end
        else
        begin : g_dly
            logic signed [PROD_W-1:0] skew_re_reg [0:DELAY-1];
            logic signed [PROD_W-1:0] skew_im_reg [0:DELAY-1];

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    skew_re_reg[0] <= prod_re_reg;
                    skew_im_reg[0] <= prod_im_reg;
                    for (int i = 1; i < DELAY; i++)
                    begin
                        skew_re_reg[i] <= skew_re_reg[i-1];
                        skew_im_reg[i] <= skew_im_reg[i-1];
                    end
                end
            end

            assign dly_re = skew_re_reg[DELAY-1];
            assign dly_im = skew_im_reg[DELAY-1];
        end
    endgenerate

    assign front_out_re = front_re_reg;
    assign front_out_im = front_im_reg;
    assign back_out_re  = back_re_reg;
    assign back_out_im  = back_im_reg;
    assign psum_out_re  = psum_re_reg;
    assign psum_out_im  = psum_im_reg;

endmodule

// ----- rtl/sfir_out.sv -----
// Output stage: arithmetic right shift, saturation and the output word register.
// Depends on sfir_pkg.
`timescale 1ns / 1ps

module sfir_out #(
    parameter int SAMPLE_WIDTH = sfir_pkg::SAMPLE_WIDTH_DEF,
    parameter int ACC_W        = 40
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  logic                              out_ready,
    input  logic [sfir_pkg::SHIFT_W-1:0]      shift,
    input  logic signed [ACC_W-1:0]           acc_re,
    input  logic signed [ACC_W-1:0]           acc_im,
    output logic                              out_valid,
    output logic signed [SAMPLE_WIDTH-1:0]    out_re,
    output logic signed [SAMPLE_WIDTH-1:0]    out_im
);

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic signed [ACC_W-1:0]        shifted_re, shifted_im;
    logic signed [SAMPLE_WIDTH-1:0] out_re_reg, out_im_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_re_next, out_im_next;

    function automatic logic signed [SAMPLE_WIDTH-1:0] clip(input logic signed [ACC_W-1:0] v);
        logic all_ones;
        logic all_zeros;
        begin
            all_ones  = &v[ACC_W-1:SAMPLE_WIDTH-1];
            all_zeros = ~|v[ACC_W-1:SAMPLE_WIDTH-1];
            if (all_ones || all_zeros)
                clip = v[SAMPLE_WIDTH-1:0];
            else if (v[ACC_W-1])
                clip = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
            else
                clip = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end
    endfunction

    // Arithmetic shift of a two's complement value rounds toward minus infinity.
    assign shifted_re  = acc_re >>> shift;
    assign shifted_im  = acc_im >>> shift;
    assign out_re_next = clip(shifted_re);
    assign out_im_next = clip(shifted_im);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_re_reg <= out_re_next;
            out_im_reg <= out_im_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_re    = out_re_reg;
    assign out_im    = out_im_reg;

endmodule

// ----- rtl/symmetric_fir_24tap_complex.sv -----
// Top level of the symmetric complex FIR filter: config registers, cell row, control.
// Depends on sfir_pkg, sfir_cell and sfir_out.
//
//   channel   signals                           direction  width
//   in        in_valid, in_ready, sample_re/im  in         SAMPLE_WIDTH each
//   out       out_valid, out_ready, out_re/im   out        SAMPLE_WIDTH each
//   cfg       cfg_valid, cfg_ready, cfg_index,  in         2 / 64
//             cfg_data
//
// One word is taken per cycle while in_ready is high. A result passes the pre-add, the
// multiply and the partial-sum chain through the cells before it is loaded into the output
// register. Results start with the 2*HALF_TAPS-th word.
// Reset clears the fill count, the pipeline valid bits and the coefficient registers, and sets the output shift to 9.
// The whole pipeline holds only when its last stage and the output register are both
// full and out_ready is low; cfg_ready is always high.
`timescale 1ns / 1ps

module symmetric_fir_24tap_complex #(
    parameter int HALF_TAPS    = sfir_pkg::HALF_TAPS_DEF,
    parameter int SAMPLE_WIDTH = sfir_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]       sample_re,
    input  logic signed [SAMPLE_WIDTH-1:0]       sample_im,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]       out_re,
    output logic signed [SAMPLE_WIDTH-1:0]       out_im,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sfir_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sfir_pkg::BANK_W-1:0]          cfg_data
);

    localparam int ACC_W    = SAMPLE_WIDTH + 1 + sfir_pkg::COEF_W + $clog2(HALF_TAPS);
    localparam int NSTG     = HALF_TAPS + 2;
    localparam int FILL_MAX = 2 * HALF_TAPS - 1;
    localparam int FILL_W   = $clog2(2 * HALF_TAPS);
    localparam int NCOEF    = sfir_pkg::COEF_REGS * sfir_pkg::COEF_PER_REG;

    logic [sfir_pkg::BANK_W-1:0]   coef_reg [0:sfir_pkg::COEF_REGS-1];
    logic [sfir_pkg::SHIFT_W-1:0]  shift_reg;
    logic [FILL_W-1:0]             fill_reg;
    logic [NSTG-1:0]               v_reg;
    logic [NSTG-1:0]               v_next;
    logic                          accept;
    logic                          full;
    logic                          adv;

    logic signed [SAMPLE_WIDTH-1:0] front_re [0:HALF_TAPS-1];
    logic signed [SAMPLE_WIDTH-1:0] front_im [0:HALF_TAPS-1];
    logic signed [SAMPLE_WIDTH-1:0] back_re  [0:HALF_TAPS-1];
    logic signed [SAMPLE_WIDTH-1:0] back_im  [0:HALF_TAPS-1];
    logic signed [ACC_W-1:0]        psum_re  [0:HALF_TAPS-1];
    logic signed [ACC_W-1:0]        psum_im  [0:HALF_TAPS-1];

    assign cfg_ready = 1'b1;
    assign adv       = !v_reg[NSTG-1] || !out_valid || out_ready;
    assign in_ready  = adv;
    assign accept    = in_valid && in_ready;
    assign full      = (fill_reg == FILL_W'(FILL_MAX));
    assign v_next    = {v_reg[NSTG-2:0], accept && full};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sfir_pkg::COEF_REGS; i++)
                coef_reg[i] <= '0;
            shift_reg <= sfir_pkg::SHIFT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (sfir_pkg::cfg_reg_t'(cfg_index))
                sfir_pkg::CFG_COEF_LOW:  coef_reg[0] <= cfg_data;
                sfir_pkg::CFG_COEF_MID:  coef_reg[1] <= cfg_data;
                sfir_pkg::CFG_COEF_HIGH: coef_reg[2] <= cfg_data;
                sfir_pkg::CFG_OUT_SHIFT: shift_reg <= cfg_data[sfir_pkg::SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            v_reg    <= '0;
        end
        else
        begin
            if (accept && !full)
                fill_reg <= fill_reg + 1'b1;
            if (adv)
                v_reg <= v_next;
        end
    end

    // Front taps run toward the last cell, fold there, and return along the back taps.
    // The last cell's back tap copies its front tap, which is the middle of the line.
    generate
        for (genvar k = 0; k < HALF_TAPS; k++)
        begin : g_cell
            logic signed [sfir_pkg::COEF_W-1:0] coef;
            logic signed [SAMPLE_WIDTH-1:0]     fin_re, fin_im, bin_re, bin_im;
            logic signed [ACC_W-1:0]            pin_re, pin_im;

            if (k < NCOEF)
            begin : g_coef
                assign coef = coef_reg[k / sfir_pkg::COEF_PER_REG]
                              [sfir_pkg::COEF_W * (k % sfir_pkg::COEF_PER_REG) +: sfir_pkg::COEF_W];
            end
            else
            begin : g_zero
                assign coef = '0;
            end

            if (k == 0)
            begin : g_first
                assign fin_re = sample_re;
                assign fin_im = sample_im;
                assign pin_re = '0;
                assign pin_im = '0;
            end
            else
            begin : g_mid
                assign fin_re = front_re[k-1];
                assign fin_im = front_im[k-1];
                assign pin_re = psum_re[k-1];
                assign pin_im = psum_im[k-1];
            end

            if (k == HALF_TAPS - 1)
            begin : g_fold
                assign bin_re = fin_re;
                assign bin_im = fin_im;
            end
            else
            begin : g_back
                assign bin_re = back_re[k+1];
                assign bin_im = back_im[k+1];
            end

            sfir_cell #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH),
                .ACC_W        (ACC_W),
                .DELAY        (k)
            ) u_cell (
                .clk          (clk),
                .shift_en     (accept),
                .adv          (adv),
                .front_in_re  (fin_re),
                .front_in_im  (fin_im),
                .back_in_re   (bin_re),
                .back_in_im   (bin_im),
                .front_out_re (front_re[k]),
                .front_out_im (front_im[k]),
                .back_out_re  (back_re[k]),
                .back_out_im  (back_im[k]),
                .coef         (coef),
                .psum_in_re   (pin_re),
                .psum_in_im   (pin_im),
                .psum_out_re  (psum_re[k]),
                .psum_out_im  (psum_im[k])
            );
        end
    endgenerate

    sfir_out #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ACC_W        (ACC_W)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (adv && v_reg[NSTG-1]),
        .out_ready (out_ready),
        .shift     (shift_reg),
        .acc_re    (psum_re[HALF_TAPS-1]),
        .acc_im    (psum_im[HALF_TAPS-1]),
        .out_valid (out_valid),
        .out_re    (out_re),
        .out_im    (out_im)
    );

    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !full) |=> !v_reg[0])
        else $error("word entered the pipeline before the delay line was full");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v_reg))
        else $error("pipeline moved while stalled");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(v_reg[NSTG-1]))
        else $error("output word appeared without a finished sum");

    // The taps hold unknown values until the line has filled, so compare exactly.
    a_fold: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (back_re[HALF_TAPS-1] === front_re[HALF_TAPS-1]) &&
                   (back_im[HALF_TAPS-1] === front_im[HALF_TAPS-1]))
        else $error("fold cell taps disagree");

endmodule
